// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is high.
`define TSPA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tspa: assertion failed");

// Concurrent check that also runs while reset is high.
`define TSPA_ASSERT_RST(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("tspa: reset check failed");

`endif

// ----- src/tspa_pkg.sv -----
package tspa_pkg;

   localparam int SLOTS  = 8;
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_W = 3;
   localparam int MASK_W = 8;
   localparam int POS_W  = 16;
   localparam int SIZE_W = 7;
   localparam int POW_W  = 7;
   localparam int TIME_W = 8;

   typedef enum logic [1:0] {
      REQ_SPAWN = 2'd0,
      REQ_TICK  = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]              req_type;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic [SIZE_W-1:0]       lifetime;
      logic [POW_W-1:0]        strength;
      logic [SLOT_W-1:0]       read_slot;
   } req_data_type;

   typedef struct packed {
      logic [SLOT_W-1:0]        slot;
      logic                     replaced;
      logic [MASK_W-1:0]        active_mask;
      logic [MASK_W-1:0]        first_frame_mask;
      logic signed [POS_W-1:0]  entry_x;
      logic signed [POS_W-1:0]  entry_y;
      logic [POW_W-1:0]         entry_power;
      logic signed [TIME_W-1:0] entry_time;
   } rsp_data_type;

   // One slot as held in the slot memory.
   typedef struct packed {
      logic [POS_W-1:0]  x;
      logic [POS_W-1:0]  y;
      logic [SIZE_W-1:0] size;
      logic [TIME_W-1:0] rem;
      logic [POW_W-1:0]  power;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_ISSUE  = 3'd1,
      ST_LAST   = 3'd2,
      ST_COMMIT = 3'd3,
      ST_RESP   = 3'd4
   } seq_state_type;

   // Sequencer to datapath controls.
   typedef struct packed {
      logic             accept;
      logic             issue;
      logic [IDX_W-1:0] scan_idx;
      logic             commit;
      logic             resp;
   } ctl_type;

endpackage

// ----- src/tspa_ram.sv -----
module tspa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/tspa_seq.sv -----
module tspa_seq (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [1:0]       req_type,
   output logic             busy,
   output tspa_pkg::ctl_type ctl
);
   import tspa_pkg::*;

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   req_kind_type     kind_ff, kind_in;
   logic             accept;
   logic             last_issue;

   assign accept     = start && (state_ff == ST_IDLE);
   assign last_issue = !((kind_ff == REQ_SPAWN) || (kind_ff == REQ_TICK)) ||
                       (idx_ff == IDX_W'(SLOTS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (start) state_in = ST_ISSUE;
         ST_ISSUE:  if (last_issue) state_in = ST_LAST;
         ST_LAST:   state_in = (kind_ff == REQ_SPAWN) ? ST_COMMIT : ST_RESP;
         ST_COMMIT: state_in = ST_RESP;
         ST_RESP:   state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      idx_in  = idx_ff;
      kind_in = kind_ff;
      if (accept) begin
         idx_in  = '0;
         kind_in = req_kind_type'(req_type);
      end else if ((state_ff == ST_ISSUE) && !last_issue) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      busy         = (state_ff != ST_IDLE);
      ctl.accept   = accept;
      ctl.issue    = (state_ff == ST_ISSUE);
      ctl.scan_idx = idx_ff;
      ctl.commit   = (state_ff == ST_COMMIT);
      ctl.resp     = (state_ff == ST_RESP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         kind_ff  <= REQ_NONE;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         kind_ff  <= kind_in;
      end
   end

endmodule

// ----- src/timed_slot_pool_allocator.sv -----
// A request runs from the accepting edge to rsp_valid through ISSUE, which walks every slot
// for spawn and tick and issues one read for read and the unused code, then LAST, then COMMIT
// for spawn only, then RESP; busy is high meanwhile. Throughput: one request at a time, the next
// start is taken the cycle after the strobe; the single read port visits one slot per cycle.
// The strobe lasts one cycle and the receiver cannot stall.
// Synchronous active-high reset empties the pool at once: per-slot valid bits, no clear pass.
module timed_slot_pool_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tspa_pkg::req_data_type req_data,
   output logic                   rsp_valid,
   output tspa_pkg::rsp_data_type rsp_data
);
   import tspa_pkg::*;

   ctl_type      ctl;
   req_data_type req_ff;
   req_kind_type kind;

   // Slot memory ports.
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_entry;
   logic [IDX_W-1:0] rd_addr;
   logic [ENTRY_W-1:0] rd_data;

   // Per-slot flags, all in flip-flops.
   logic [SLOTS-1:0] vld_ff, vld_in;
   logic [SLOTS-1:0] active_ff, active_in;
   logic [SLOTS-1:0] first_ff, first_in;

   // Read stage: a slot read issued last cycle is processed now.
   logic             proc_ff;
   logic [IDX_W-1:0] pidx_ff;
   logic             rvld_ff;
   entry_type        cur;
   logic signed [TIME_W-1:0] cur_t;

   // Spawn choice tracking.
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         pick_ff, pick_in;
   logic                     havelow_ff, havelow_in;
   logic [IDX_W-1:0]         low_ff, low_in;
   logic signed [TIME_W-1:0] lowt_ff, lowt_in;
   logic [IDX_W-1:0]         spawn_idx;

   // Tick write-back.
   logic                     tick_wr;
   logic [TIME_W-1:0]        tick_t;

   rsp_data_type res_ff, res_in;

   tspa_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_type (req_data.req_type),
      .busy     (busy),
      .ctl      (ctl)
   );

   tspa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (ctl.issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign kind = req_kind_type'(req_ff.req_type);

   // Read walks the pool for spawn and tick, or hits the one requested slot.
   assign rd_addr = (kind == REQ_READ) ? IDX_W'(req_ff.read_slot) : ctl.scan_idx;

   // A slot never written since reset reads as zero; so does a read beyond the pool.
   assign cur   = rvld_ff ? entry_type'(rd_data) : '0;
   assign cur_t = $signed(cur.rem);

   assign spawn_idx = found_ff ? pick_ff : low_ff;

   // Tick: only active slots are touched, each written back in the cycle it is seen.
   // The scan reads one slot ahead of the write, so read and write never collide.
   assign tick_wr = proc_ff && (kind == REQ_TICK) && active_ff[pidx_ff];
   assign tick_t  = cur.rem - TIME_W'(1);

   always_comb begin
      wr_en    = tick_wr || ctl.commit;
      wr_addr  = ctl.commit ? spawn_idx : pidx_ff;
      wr_entry = cur;
      wr_entry.rem = tick_t;
      if (ctl.commit) begin
         wr_entry.x     = req_ff.pos_x;
         wr_entry.y     = req_ff.pos_y;
         wr_entry.size  = req_ff.lifetime;
         wr_entry.rem   = TIME_W'(req_ff.lifetime);
         wr_entry.power = req_ff.strength;
      end
   end

   // Flag updates.
   always_comb begin
      vld_in    = vld_ff;
      active_in = active_ff;
      first_in  = first_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
      if (tick_wr) begin
         first_in[pidx_ff] = (cur.rem == TIME_W'(cur.size));
         if (tick_t[TIME_W-1]) begin
            active_in[pidx_ff] = 1'b0;
         end
      end
      if (ctl.commit) begin
         first_in[spawn_idx]  = 1'b0;
         active_in[spawn_idx] = 1'b1;
      end
   end

   // Spawn choice: first free slot wins; otherwise the earliest strictly lowest time.
   always_comb begin
      found_in   = found_ff;
      pick_in    = pick_ff;
      havelow_in = havelow_ff;
      low_in     = low_ff;
      lowt_in    = lowt_ff;
      if (ctl.accept) begin
         found_in   = 1'b0;
         havelow_in = 1'b0;
      end else if (proc_ff && (kind == REQ_SPAWN) && !found_ff) begin
         if (cur_t <= 0) begin
            found_in = 1'b1;
            pick_in  = pidx_ff;
         end else if (!havelow_ff || (cur_t < lowt_ff)) begin
            havelow_in = 1'b1;
            low_in     = pidx_ff;
            lowt_in    = cur_t;
         end
      end
   end

   // Result register: cleared at accept, filled by the read stage or the commit.
   always_comb begin
      res_in = res_ff;
      if (ctl.accept) begin
         res_in = '0;
         if (req_kind_type'(req_data.req_type) == REQ_READ) begin
            res_in.slot = req_data.read_slot;
         end
      end else if (proc_ff && (kind == REQ_READ)) begin
         res_in.entry_x     = cur.x;
         res_in.entry_y     = cur.y;
         res_in.entry_power = cur.power;
         res_in.entry_time  = cur.rem;
      end else if (ctl.commit) begin
         res_in.slot        = SLOT_W'(spawn_idx);
         res_in.replaced    = !found_ff;
         res_in.entry_x     = req_ff.pos_x;
         res_in.entry_y     = req_ff.pos_y;
         res_in.entry_power = req_ff.strength;
         res_in.entry_time  = TIME_W'(req_ff.lifetime);
      end
   end

   // Masks are final by the response cycle, so take them live.
   always_comb begin
      rsp_valid                 = ctl.resp;
      rsp_data                  = res_ff;
      rsp_data.active_mask      = MASK_W'(active_ff);
      rsp_data.first_frame_mask = MASK_W'(first_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         active_ff  <= '0;
         first_ff   <= '0;
         proc_ff    <= 1'b0;
         found_ff   <= 1'b0;
         havelow_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         active_ff  <= active_in;
         first_ff   <= first_in;
         proc_ff    <= ctl.issue;
         found_ff   <= found_in;
         havelow_ff <= havelow_in;
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         req_ff <= req_data;
      end
      if (ctl.issue) begin
         pidx_ff <= rd_addr;
         rvld_ff <= (int'(rd_addr) < SLOTS) ? vld_ff[rd_addr] : 1'b0;
      end
      pick_ff <= pick_in;
      low_ff  <= low_in;
      lowt_ff <= lowt_in;
      res_ff  <= res_in;
   end

endmodule

// ----- src/tspa_checker.sv -----
`include "assert_macros.svh"

module tspa_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input tspa_pkg::rsp_data_type rsp_data
);
   import tspa_pkg::*;

   // A taken request holds the block busy until its response.
   `TSPA_ASSERT(a_accept_busy, clock, reset, (start && !busy) |=> busy)

   // One response per request, never two in a row.
   `TSPA_ASSERT(a_single_rsp, clock, reset, rsp_valid |=> !rsp_valid && !busy)

   // Eviction only happens when every slot is running.
   `TSPA_ASSERT(a_evict_full, clock, reset, (rsp_valid && rsp_data.replaced) |-> (rsp_data.active_mask == MASK_W'({SLOTS{1'b1}})))

   // Reset drops any request in flight.
   `TSPA_ASSERT_RST(a_reset_idle, clock, reset |=> (!busy && !rsp_valid))

endmodule

bind timed_slot_pool_allocator tspa_checker u_tspa_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
